[rtl/dcfl_pkg.sv]
// ----------------------------------------------------------------------------
// dcfl_pkg
// Shared types and constants of the certificate field locator.
// ----------------------------------------------------------------------------
`default_nettype none

package dcfl_pkg;

	// Parser phase, one-hot
	typedef enum logic [4:0] {
		PH_TAG  = 5'b00001,
		PH_LEN  = 5'b00010,
		PH_LLEN = 5'b00100,
		PH_SKIP = 5'b01000,
		PH_DONE = 5'b10000
	} phase_t;

	// Level 3 element indexes that are captured, and the element count
	localparam logic [2:0] ELEM_SERIAL  = 3'd1;
	localparam logic [2:0] ELEM_ISSUER  = 3'd3;
	localparam logic [2:0] ELEM_SUBJECT = 3'd5;
	localparam logic [2:0] ELEM_COUNT   = 3'd6;

	localparam logic [7:0] LEN_LONG_FLAG = 8'h80;

	localparam int FIELD_W = 16;

	// One input beat after the input register
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} in_beat_t;

	// One result beat
	typedef struct packed {
		logic               status;
		logic [FIELD_W-1:0] serial_offset;
		logic [FIELD_W-1:0] serial_length;
		logic [FIELD_W-1:0] issuer_offset;
		logic [FIELD_W-1:0] issuer_length;
		logic [FIELD_W-1:0] subject_offset;
		logic [FIELD_W-1:0] subject_length;
	} result_t;

endpackage

`default_nettype wire

[rtl/der_certificate_field_locator_core.sv]
// ----------------------------------------------------------------------------
// der_certificate_field_locator_core
// Streaming DER/BER certificate walker that locates serial, issuer, subject.
// ----------------------------------------------------------------------------
// Feed the certificate one byte per beat on the input channel and mark its
// final byte with is_last. The block walks the outer sequence, the body and
// the first six body elements, and on the last byte delivers exactly one
// result beat: status (0 good, 1 malformed or truncated) plus tag offset and
// full encoded length (header included) of serial, issuer and subject, all
// zero on a bad status. The byte register, the walker update and the result
// register let one byte in per clock, apart from the stall described next;
// out_valid rises when the result register loads the result computed on
// the held last byte. Input stalls only while a finished result waits
// in the result register and the byte held is itself a last byte. Offsets
// count from 0 at the first byte of each certificate; POSITION_WIDTH sets
// the offset and length counters (offsets saturate at 2^POSITION_WIDTH-1,
// longer streams are reported malformed). No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module der_certificate_field_locator_core #(
	parameter int POSITION_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        is_last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             status,
	output logic [15:0]      serial_offset,
	output logic [15:0]      serial_length,
	output logic [15:0]      issuer_offset,
	output logic [15:0]      issuer_length,
	output logic [15:0]      subject_offset,
	output logic [15:0]      subject_length
);
	import dcfl_pkg::*;

	logic     valid_s1;
	in_beat_t beat_s1;
	logic     advance;
	logic     can_load;
	result_t  res_s1;
	result_t  res_q;

	// a held byte moves on unless it is a last byte and the result slot is busy
	assign advance = valid_s1 && (!beat_s1.last || can_load);

	dcfl_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.is_last   (is_last),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.beat_s1   (beat_s1)
	);

	// per-byte TLV state update; result is combinational from the held beat
	dcfl_walker #(
		.POS_W (POSITION_WIDTH)
	) u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.beat   (beat_s1),
		.result (res_s1)
	);

	// one result beat per certificate, loaded on the last byte
	dcfl_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && beat_s1.last),
		.res_in    (res_s1),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign status         = res_q.status;
	assign serial_offset  = res_q.serial_offset;
	assign serial_length  = res_q.serial_length;
	assign issuer_offset  = res_q.issuer_offset;
	assign issuer_length  = res_q.issuer_length;
	assign subject_offset = res_q.subject_offset;
	assign subject_length = res_q.subject_length;

endmodule

`default_nettype wire

[rtl/dcfl_in_reg.sv]
// ----------------------------------------------------------------------------
// dcfl_in_reg
// Input register: holds one byte beat until the walker consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dcfl_in_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        data_byte,
	input  wire logic              is_last,
	input  wire logic              advance,
	output logic                   valid_s1,
	output dcfl_pkg::in_beat_t     beat_s1
);
	import dcfl_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1.data <= data_byte;
			beat_s1.last <= is_last;
		end
	end

endmodule

`default_nettype wire

[rtl/dcfl_walker.sv]
// ----------------------------------------------------------------------------
// dcfl_walker
// TLV walker state: three nesting levels, lengths, captures, final verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module dcfl_walker #(
	parameter int POS_W = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire dcfl_pkg::in_beat_t beat,
	output dcfl_pkg::result_t       result
);
	import dcfl_pkg::*;

	localparam int SUM_W = (POS_W + 2 > FIELD_W) ? POS_W + 2 : FIELD_W;
	localparam logic [POS_W-1:0] LIMIT = {POS_W{1'b1}};

	logic [POS_W-1:0]   pos_q, pos_n;
	phase_t             phase_q, phase_n;
	logic [1:0]         lvl_q, lvl_n;
	logic [POS_W-1:0]   rr0_q, rr0_n, rr1_q, rr1_n, rr2_q, rr2_n;
	logic [2:0]         idx_q, idx_n;
	logic [POS_W-1:0]   acc_q, acc_n;
	logic [6:0]         left_q, left_n;
	logic [POS_W-1:0]   start_q, start_n;
	logic               err_q, err_n;
	logic [FIELD_W-1:0] cap_q [6];
	logic [FIELD_W-1:0] cap_n [6];

	logic               empty;
	logic               hc_go;
	logic [POS_W-1:0]   hc_size;
	logic [POS_W-1:0]   parent;
	logic [POS_W+7:0]   acc_wide;
	logic [SUM_W-1:0]   full_len;
	logic [SUM_W-1:0]   start_ext;
	logic               bad;

	always_comb begin
		pos_n   = (pos_q < LIMIT) ? pos_q + 1'b1 : pos_q;
		phase_n = phase_q;
		lvl_n   = lvl_q;
		rr0_n   = rr0_q;
		rr1_n   = rr1_q;
		rr2_n   = rr2_q;
		idx_n   = idx_q;
		acc_n   = acc_q;
		left_n  = left_q;
		start_n = start_q;
		err_n   = err_q;
		cap_n   = cap_q;
		empty   = 1'b0;
		hc_go   = 1'b0;
		hc_size = '0;
		parent  = rr1_q;
		acc_wide = {acc_q, beat.data};
		start_ext = SUM_W'(start_q);
		full_len  = '0;

		if (!err_q) begin
			if (pos_q == LIMIT && (phase_q != PH_DONE || rr0_q != '0)) begin
				err_n = 1'b1;
			end else begin
				if (lvl_q >= 2'd1 && rr0_q != '0) rr0_n = rr0_q - 1'b1;
				if (lvl_q >= 2'd2 && rr1_q != '0) rr1_n = rr1_q - 1'b1;
				if (phase_q == PH_SKIP && rr2_q != '0) rr2_n = rr2_q - 1'b1;

				if (lvl_q == 2'd0)      empty = beat.last;
				else if (lvl_q == 2'd1) empty = (rr0_n == '0);
				else                    empty = (rr1_n == '0);

				unique case (phase_q)
					PH_TAG: begin
						start_n = pos_q;
						if (empty) err_n = 1'b1;
						else       phase_n = PH_LEN;
					end
					PH_LEN: begin
						if (empty) begin
							err_n = 1'b1;
						end else if ((beat.data & LEN_LONG_FLAG) != 8'h00) begin
							acc_n  = '0;
							left_n = beat.data[6:0];
							if (beat.data[6:0] == 7'd0) hc_go = 1'b1;
							else                        phase_n = PH_LLEN;
						end else begin
							hc_go   = 1'b1;
							hc_size = POS_W'(beat.data[6:0]);
						end
					end
					PH_LLEN: begin
						acc_n = acc_wide[POS_W-1:0];
						if ((acc_wide[POS_W+7:POS_W] != 8'h00) || empty) begin
							err_n = 1'b1;
						end else begin
							left_n = left_q - 1'b1;
							if (left_n == 7'd0) begin
								hc_go   = 1'b1;
								hc_size = acc_wide[POS_W-1:0];
							end
						end
					end
					PH_SKIP: begin
						if (rr2_n == '0) begin
							if (idx_q >= ELEM_COUNT)  phase_n = PH_DONE;
							else if (rr1_n == '0)     err_n = 1'b1;
							else                      phase_n = PH_TAG;
						end
					end
					PH_DONE: begin
					end
					default: begin
					end
				endcase

				// header complete: size known
				parent = (lvl_q == 2'd1) ? rr0_n : rr1_n;
				if (hc_go) begin
					if (lvl_q != 2'd0 && hc_size > parent) begin
						err_n = 1'b1;
					end else if (lvl_q < 2'd2) begin
						if (lvl_q == 2'd0) rr0_n = hc_size;
						else               rr1_n = hc_size;
						lvl_n   = lvl_q + 1'b1;
						phase_n = PH_TAG;
						if (hc_size == '0) err_n = 1'b1;
					end else begin
						full_len = SUM_W'(pos_q) + SUM_W'(1) - start_ext + SUM_W'(hc_size);
						case (idx_q)
							ELEM_SERIAL: begin
								cap_n[0] = start_ext[FIELD_W-1:0];
								cap_n[1] = full_len[FIELD_W-1:0];
							end
							ELEM_ISSUER: begin
								cap_n[2] = start_ext[FIELD_W-1:0];
								cap_n[3] = full_len[FIELD_W-1:0];
							end
							ELEM_SUBJECT: begin
								cap_n[4] = start_ext[FIELD_W-1:0];
								cap_n[5] = full_len[FIELD_W-1:0];
							end
							default: begin
							end
						endcase
						rr2_n = hc_size;
						idx_n = idx_q + 1'b1;
						if (hc_size != '0)           phase_n = PH_SKIP;
						else if (idx_n >= ELEM_COUNT) phase_n = PH_DONE;
						else if (rr1_n == '0)        err_n = 1'b1;
						else                         phase_n = PH_TAG;
					end
				end
			end
		end

		bad = err_n || (phase_n != PH_DONE) || (rr0_n != '0);
		result.status         = bad;
		result.serial_offset  = bad ? '0 : cap_n[0];
		result.serial_length  = bad ? '0 : cap_n[1];
		result.issuer_offset  = bad ? '0 : cap_n[2];
		result.issuer_length  = bad ? '0 : cap_n[3];
		result.subject_offset = bad ? '0 : cap_n[4];
		result.subject_length = bad ? '0 : cap_n[5];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= PH_TAG;
			lvl_q   <= 2'd0;
			rr0_q   <= '0;
			rr1_q   <= '0;
			rr2_q   <= '0;
			idx_q   <= 3'd0;
			acc_q   <= '0;
			left_q  <= 7'd0;
			start_q <= '0;
			err_q   <= 1'b0;
		end else if (step) begin
			if (beat.last) begin
				// next certificate starts from scratch
				pos_q   <= '0;
				phase_q <= PH_TAG;
				lvl_q   <= 2'd0;
				rr0_q   <= '0;
				rr1_q   <= '0;
				rr2_q   <= '0;
				idx_q   <= 3'd0;
				acc_q   <= '0;
				left_q  <= 7'd0;
				start_q <= '0;
				err_q   <= 1'b0;
			end else begin
				pos_q   <= pos_n;
				phase_q <= phase_n;
				lvl_q   <= lvl_n;
				rr0_q   <= rr0_n;
				rr1_q   <= rr1_n;
				rr2_q   <= rr2_n;
				idx_q   <= idx_n;
				acc_q   <= acc_n;
				left_q  <= left_n;
				start_q <= start_n;
				err_q   <= err_n;
			end
		end
	end

	// captures only matter once all six elements are seen; no reset needed
	always_ff @(posedge clk) begin
		if (step) begin
			cap_q <= cap_n;
		end
	end

	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q != 2'd3)
		else $error("nesting level out of range");

	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |-> idx_q == ELEM_COUNT && lvl_q == 2'd2)
		else $error("done before all six elements");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && beat.last |=> pos_q == '0 && phase_q == PH_TAG && !err_q)
		else $error("state not cleared after last beat");

	a_skip_level: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> lvl_q == 2'd2 && idx_q != 3'd0)
		else $error("skip outside level 3");

endmodule

`default_nettype wire

[rtl/dcfl_out_reg.sv]
// ----------------------------------------------------------------------------
// dcfl_out_reg
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dcfl_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire dcfl_pkg::result_t res_in,
	output logic                   can_load,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output dcfl_pkg::result_t      res_q
);
	import dcfl_pkg::*;

	assign can_load = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (can_load) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			res_q <= res_in;
		end
	end

endmodule

`default_nettype wire
